/* rtl/core/rbtq_pkg.sv */
`default_nettype none

package rbtq_pkg;

   localparam int unsigned KIND_BITS    = 2;
   localparam int unsigned HANDLE_W     = 16;
   localparam int unsigned RLEVEL_W     = 9;
   localparam int unsigned BLEVEL_W     = 8;
   localparam int unsigned TOTAL_W      = 32;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_PUSH    = 2'd0,
      KIND_POP     = 2'd1,
      KIND_APPEND  = 2'd2,
      KIND_UNBLOCK = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type              kind;
      logic [HANDLE_W-1:0]   task_handle;
   } req_type;

   typedef struct packed {
      logic                  ok;
      logic [HANDLE_W-1:0]   popped_handle;
      logic [RLEVEL_W-1:0]   ready_level;
      logic [BLEVEL_W-1:0]   blocked_level;
      logic [TOTAL_W-1:0]    pushed_total;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_POP,
      ST_SEARCH,
      ST_SHIFT,
      ST_DONE
   } ctl_state_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic pop_load;
      logic search;
      logic shift;
      logic load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     pop_go;
      logic     unb_go;
      logic     search_hit;
      logic     search_miss;
      logic     shift_done;
      logic     out_free;
   } dp_sts_type;

endpackage

`default_nettype wire

/* rtl/core/rbtq_ctrl.sv */
`default_nettype none

module rbtq_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire rbtq_pkg::dp_sts_type sts,
   output rbtq_pkg::dp_cmd_type     cmd
);

   rbtq_pkg::ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rbtq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         rbtq_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = rbtq_pkg::ST_EXEC;
            end
         end
         rbtq_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
            unique case (sts.kind)
               rbtq_pkg::KIND_POP: begin
                  state_in = sts.pop_go ? rbtq_pkg::ST_POP : rbtq_pkg::ST_DONE;
               end
               rbtq_pkg::KIND_UNBLOCK: begin
                  state_in = sts.unb_go ? rbtq_pkg::ST_SEARCH : rbtq_pkg::ST_DONE;
               end
               default: begin
                  state_in = rbtq_pkg::ST_DONE;
               end
            endcase
         end
         rbtq_pkg::ST_POP: begin
            cmd.pop_load = 1'b1;
            state_in     = rbtq_pkg::ST_DONE;
         end
         rbtq_pkg::ST_SEARCH: begin
            cmd.search = 1'b1;
            if (sts.search_hit) begin
               state_in = rbtq_pkg::ST_SHIFT;
            end else if (sts.search_miss) begin
               state_in = rbtq_pkg::ST_DONE;
            end
         end
         rbtq_pkg::ST_SHIFT: begin
            cmd.shift = 1'b1;
            if (sts.shift_done) begin
               state_in = rbtq_pkg::ST_DONE;
            end
         end
         rbtq_pkg::ST_DONE: begin
            if (sts.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = rbtq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rbtq_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

/* rtl/core/rbtq_datapath.sv */
`default_nettype none

module rbtq_datapath #(
   parameter int unsigned READY_DEPTH   = 256,
   parameter int unsigned BLOCKED_DEPTH = 128,
   parameter int unsigned HANDLE_BITS   = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire rbtq_pkg::req_type    req_item,
   input  wire rbtq_pkg::dp_cmd_type cmd,
   output rbtq_pkg::dp_sts_type      sts,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output rbtq_pkg::rsp_type         rsp_item
);

   localparam int unsigned RCW = $clog2(READY_DEPTH + 1);
   localparam int unsigned RAW = $clog2(READY_DEPTH);
   localparam int unsigned BCW = $clog2(BLOCKED_DEPTH + 1);
   localparam int unsigned BAW = (BLOCKED_DEPTH > 1) ? $clog2(BLOCKED_DEPTH) : 1;
   localparam int unsigned HW  = (HANDLE_BITS < rbtq_pkg::HANDLE_W) ? HANDLE_BITS
                                                                  : rbtq_pkg::HANDLE_W;

   logic [HW-1:0] rmem [READY_DEPTH];
   logic [HW-1:0] bmem [BLOCKED_DEPTH];

   rbtq_pkg::kind_type          kind_ff, kind_in;
   logic [HW-1:0]               hnd_ff, hnd_in;
   logic [RCW-1:0]              rdy_cnt_ff, rdy_cnt_in;
   logic [BCW-1:0]              blk_cnt_ff, blk_cnt_in;
   logic [rbtq_pkg::TOTAL_W-1:0] total_ff, total_in;
   logic                        ok_ff, ok_in;
   logic [HW-1:0]               popped_ff, popped_in;
   logic [BCW-1:0]              idx_ff, idx_in;
   logic [BAW-1:0]              cmp_idx_ff, cmp_idx_in;
   logic                        cmp_vld_ff, cmp_vld_in;
   logic [BAW-1:0]              wr_idx_ff, wr_idx_in;
   logic                        sh_vld_ff, sh_vld_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   rbtq_pkg::rsp_type           rsp_ff, rsp_in;

   logic                        rwe;
   logic [RAW-1:0]              rwa, rra;
   logic [HW-1:0]               rwd, rmem_q;
   logic                        bwe;
   logic [BAW-1:0]              bwa, bra;
   logic [HW-1:0]               bwd, bmem_q;

   logic [RCW-1:0]              rdy_dec;
   logic                        hnd_nz, rdy_room, blk_room, hit;

   always_ff @(posedge clock) begin
      if (rwe) begin
         rmem[rwa] <= rwd;
      end
      rmem_q <= rmem[rra];
   end

   always_ff @(posedge clock) begin
      if (bwe) begin
         bmem[bwa] <= bwd;
      end
      bmem_q <= bmem[bra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rdy_cnt_ff   <= '0;
         blk_cnt_ff   <= '0;
         total_ff     <= '0;
         cmp_vld_ff   <= 1'b0;
         sh_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rdy_cnt_ff   <= rdy_cnt_in;
         blk_cnt_ff   <= blk_cnt_in;
         total_ff     <= total_in;
         cmp_vld_ff   <= cmp_vld_in;
         sh_vld_ff    <= sh_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      hnd_ff     <= hnd_in;
      ok_ff      <= ok_in;
      popped_ff  <= popped_in;
      idx_ff     <= idx_in;
      cmp_idx_ff <= cmp_idx_in;
      wr_idx_ff  <= wr_idx_in;
      rsp_ff     <= rsp_in;
   end

   assign rdy_dec  = rdy_cnt_ff - RCW'(1);
   assign hnd_nz   = (hnd_ff != '0);
   assign rdy_room = (rdy_cnt_ff < RCW'(READY_DEPTH));
   assign blk_room = (blk_cnt_ff < BCW'(BLOCKED_DEPTH));
   assign hit      = cmp_vld_ff && (bmem_q == hnd_ff);

   always_comb begin
      kind_in      = kind_ff;
      hnd_in       = hnd_ff;
      rdy_cnt_in   = rdy_cnt_ff;
      blk_cnt_in   = blk_cnt_ff;
      total_in     = total_ff;
      ok_in        = ok_ff;
      popped_in    = popped_ff;
      idx_in       = idx_ff;
      cmp_idx_in   = cmp_idx_ff;
      cmp_vld_in   = cmp_vld_ff;
      wr_idx_in    = wr_idx_ff;
      sh_vld_in    = sh_vld_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      rwe = 1'b0;
      rwa = rdy_cnt_ff[RAW-1:0];
      rwd = hnd_ff;
      rra = rdy_dec[RAW-1:0];
      bwe = 1'b0;
      bwa = blk_cnt_ff[BAW-1:0];
      bwd = hnd_ff;
      bra = idx_ff[BAW-1:0];

      if (cmd.capture) begin
         kind_in   = req_item.kind;
         hnd_in    = HW'(req_item.task_handle);
         ok_in     = 1'b0;
         popped_in = '0;
      end

      if (cmd.exec) begin
         unique case (kind_ff)
            rbtq_pkg::KIND_PUSH: begin
               if (hnd_nz && rdy_room) begin
                  rwe        = 1'b1;
                  rdy_cnt_in = rdy_cnt_ff + RCW'(1);
                  total_in   = total_ff + rbtq_pkg::TOTAL_W'(1);
                  ok_in      = 1'b1;
               end
            end
            rbtq_pkg::KIND_POP: begin
               if (rdy_cnt_ff != '0) begin
                  rdy_cnt_in = rdy_dec;
                  ok_in      = 1'b1;
               end
            end
            rbtq_pkg::KIND_APPEND: begin
               if (hnd_nz && blk_room) begin
                  bwe        = 1'b1;
                  blk_cnt_in = blk_cnt_ff + BCW'(1);
                  ok_in      = 1'b1;
               end
            end
            rbtq_pkg::KIND_UNBLOCK: begin
               idx_in     = '0;
               cmp_vld_in = 1'b0;
            end
            default: begin
               ok_in = 1'b0;
            end
         endcase
      end

      if (cmd.pop_load) begin
         popped_in = rmem_q;
      end

      // search: one read per cycle, each entry compared in the cycle after its read
      if (cmd.search) begin
         if (hit) begin
            rwe        = 1'b1;
            rdy_cnt_in = rdy_cnt_ff + RCW'(1);
            blk_cnt_in = blk_cnt_ff - BCW'(1);
            ok_in      = 1'b1;
            idx_in     = BCW'(cmp_idx_ff) + BCW'(1);
            wr_idx_in  = cmp_idx_ff;
            sh_vld_in  = 1'b0;
            cmp_vld_in = 1'b0;
         end else if (idx_ff < blk_cnt_ff) begin
            cmp_vld_in = 1'b1;
            cmp_idx_in = idx_ff[BAW-1:0];
            idx_in     = idx_ff + BCW'(1);
         end else begin
            cmp_vld_in = 1'b0;
         end
      end

      // compaction: read entry k+1, write it back at k next cycle
      if (cmd.shift) begin
         if (sh_vld_ff) begin
            bwe       = 1'b1;
            bwa       = wr_idx_ff;
            bwd       = bmem_q;
            wr_idx_in = wr_idx_ff + BAW'(1);
         end
         if (idx_ff <= blk_cnt_ff) begin
            sh_vld_in = 1'b1;
            idx_in    = idx_ff + BCW'(1);
         end else begin
            sh_vld_in = 1'b0;
         end
      end

      if (cmd.load_rsp) begin
         rsp_valid_in         = 1'b1;
         rsp_in.ok            = ok_ff;
         rsp_in.popped_handle = rbtq_pkg::HANDLE_W'(popped_ff);
         rsp_in.ready_level   = rbtq_pkg::RLEVEL_W'(rdy_cnt_ff);
         rsp_in.blocked_level = rbtq_pkg::BLEVEL_W'(blk_cnt_ff);
         rsp_in.pushed_total  = total_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      sts             = '0;
      sts.kind        = kind_ff;
      sts.pop_go      = (rdy_cnt_ff != '0);
      sts.unb_go      = hnd_nz && (blk_cnt_ff != '0) && rdy_room;
      sts.search_hit  = hit;
      sts.search_miss = !cmp_vld_ff && (idx_ff >= blk_cnt_ff);
      sts.shift_done  = !sh_vld_ff && (idx_ff > blk_cnt_ff);
      sts.out_free    = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

`default_nettype wire

/* rtl/core/ready_blocked_task_queues.sv */
// Sequence: an item passes EXEC, then DONE, which loads the result once the output
// register is free; a pop of a ready entry adds POP, an unblock adds SEARCH up to the
// match, then SHIFT compacts the entries behind it, one blocked-list read per cycle.
// Throughput: one item in flight; the next item is accepted once the result is
// loaded into the output register, even while that result waits for rsp_ready.
// Reset: synchronous; clears counts, push total and rsp_valid; stores are not cleared.
`default_nettype none

module ready_blocked_task_queues #(
   parameter int unsigned READY_DEPTH   = 256,
   parameter int unsigned BLOCKED_DEPTH = 128,
   parameter int unsigned HANDLE_BITS   = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire rbtq_pkg::req_type req_item,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rbtq_pkg::rsp_type      rsp_item
);

   rbtq_pkg::dp_cmd_type cmd;
   rbtq_pkg::dp_sts_type sts;

   rbtq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rbtq_datapath #(
      .READY_DEPTH   (READY_DEPTH),
      .BLOCKED_DEPTH (BLOCKED_DEPTH),
      .HANDLE_BITS   (HANDLE_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

endmodule

`default_nettype wire

/* rtl/core/rbtq_checker.sv */
`default_nettype none

module rbtq_checker #(
   parameter int unsigned READY_DEPTH   = 256,
   parameter int unsigned BLOCKED_DEPTH = 128
) (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire rbtq_pkg::req_type req_item,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire rbtq_pkg::rsp_type rsp_item
);

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_item))
      else $error("request item dropped or changed while waiting");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("result item dropped or changed while stalled");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_levels: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.ready_level <= rbtq_pkg::RLEVEL_W'(READY_DEPTH)) &&
                    (rsp_item.blocked_level <= rbtq_pkg::BLEVEL_W'(BLOCKED_DEPTH)))
      else $error("store level beyond depth");

   a_popped_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.popped_handle != '0) |-> rsp_item.ok)
      else $error("popped handle on a failed item");

endmodule

bind ready_blocked_task_queues rbtq_checker #(
   .READY_DEPTH   (READY_DEPTH),
   .BLOCKED_DEPTH (BLOCKED_DEPTH)
) u_rbtq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_item  (rsp_item)
);

`default_nettype wire

/* verif/testbench.sv */
module testbench;

   localparam int unsigned READY_DEPTH   = 256;
   localparam int unsigned BLOCKED_DEPTH = 128;
   localparam int unsigned HANDLE_BITS   = 16;
   localparam int unsigned RANDOM_ITEMS  = 1100;
   localparam int unsigned PHASE_ITEMS   = 275;
   localparam int unsigned SETTLE_CYCLES = 2 * BLOCKED_DEPTH + 16;
   localparam longint unsigned CYCLE_LIMIT = 2_000_000;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;
   typedef enum int {MIX_EVEN, MIX_FILL, MIX_DRAIN} op_mix_type;

   typedef struct packed {
      rbtq_pkg::kind_type            kind;
      logic [rbtq_pkg::HANDLE_W-1:0] task_handle;
      logic                          typed;
      rbtq_pkg::rsp_type             want;
   } opening_row_type;

   localparam int unsigned OPENING_ROWS = 25;
   localparam opening_row_type OPENING_OPS [OPENING_ROWS] = '{
      '{rbtq_pkg::KIND_POP,     16'h0000, 1'b1, '{1'b0, 16'h0000, 9'd0, 8'd0, 32'd0}},
      '{rbtq_pkg::KIND_PUSH,    16'h0000, 1'b1, '{1'b0, 16'h0000, 9'd0, 8'd0, 32'd0}},
      '{rbtq_pkg::KIND_APPEND,  16'h0000, 1'b1, '{1'b0, 16'h0000, 9'd0, 8'd0, 32'd0}},
      '{rbtq_pkg::KIND_UNBLOCK, 16'h0000, 1'b1, '{1'b0, 16'h0000, 9'd0, 8'd0, 32'd0}},
      '{rbtq_pkg::KIND_UNBLOCK, 16'h0005, 1'b1, '{1'b0, 16'h0000, 9'd0, 8'd0, 32'd0}},
      '{rbtq_pkg::KIND_PUSH,    16'hFFFF, 1'b1, '{1'b1, 16'h0000, 9'd1, 8'd0, 32'd1}},
      '{rbtq_pkg::KIND_PUSH,    16'h0001, 1'b1, '{1'b1, 16'h0000, 9'd2, 8'd0, 32'd2}},
      '{rbtq_pkg::KIND_POP,     16'h0000, 1'b1, '{1'b1, 16'h0001, 9'd1, 8'd0, 32'd2}},
      '{rbtq_pkg::KIND_POP,     16'hFFFF, 1'b1, '{1'b1, 16'hFFFF, 9'd0, 8'd0, 32'd2}},
      '{rbtq_pkg::KIND_APPEND,  16'h00AA, 1'b1, '{1'b1, 16'h0000, 9'd0, 8'd1, 32'd2}},
      '{rbtq_pkg::KIND_APPEND,  16'hFFFF, 1'b1, '{1'b1, 16'h0000, 9'd0, 8'd2, 32'd2}},
      '{rbtq_pkg::KIND_APPEND,  16'h00AA, 1'b1, '{1'b1, 16'h0000, 9'd0, 8'd3, 32'd2}},
      '{rbtq_pkg::KIND_APPEND,  16'h5555, 1'b1, '{1'b1, 16'h0000, 9'd0, 8'd4, 32'd2}},
      '{rbtq_pkg::KIND_UNBLOCK, 16'h00AA, 1'b1, '{1'b1, 16'h0000, 9'd1, 8'd3, 32'd2}},
      '{rbtq_pkg::KIND_UNBLOCK, 16'h1234, 1'b1, '{1'b0, 16'h0000, 9'd1, 8'd3, 32'd2}},
      '{rbtq_pkg::KIND_POP,     16'h0000, 1'b1, '{1'b1, 16'h00AA, 9'd0, 8'd3, 32'd2}},
      '{rbtq_pkg::KIND_PUSH,    16'h8000, 1'b0, '0},
      '{rbtq_pkg::KIND_UNBLOCK, 16'h5555, 1'b0, '0},
      '{rbtq_pkg::KIND_UNBLOCK, 16'h00AA, 1'b0, '0},
      '{rbtq_pkg::KIND_APPEND,  16'h7FFF, 1'b0, '0},
      '{rbtq_pkg::KIND_UNBLOCK, 16'hFFFF, 1'b0, '0},
      '{rbtq_pkg::KIND_UNBLOCK, 16'h7FFF, 1'b0, '0},
      '{rbtq_pkg::KIND_POP,     16'h0000, 1'b0, '0},
      '{rbtq_pkg::KIND_POP,     16'h0000, 1'b0, '0},
      '{rbtq_pkg::KIND_POP,     16'h0000, 1'b0, '0}
   };

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   rbtq_pkg::req_type req_item = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rbtq_pkg::rsp_type rsp_item;

   idle_mode_type idle_mode = IDLE_BOTH;

   logic [rbtq_pkg::HANDLE_W-1:0] ready_mem [READY_DEPTH];
   int unsigned                   ready_cnt;
   logic [rbtq_pkg::HANDLE_W-1:0] blocked_list [$];
   logic [rbtq_pkg::TOTAL_W-1:0]  push_total = '0;

   rbtq_pkg::rsp_type awaited_rsp [$];
   rbtq_pkg::rsp_type head_rsp;
   int unsigned       mismatches;
   int unsigned       items_sent;
   int unsigned       results_checked;
   int unsigned       ready_peak;
   int unsigned       blocked_peak;
   int unsigned       full_push_refusals;
   int unsigned       full_append_refusals;
   int unsigned       held_unblocks;
   longint unsigned   cycles;

   ready_blocked_task_queues #(
      .READY_DEPTH   (READY_DEPTH),
      .BLOCKED_DEPTH (BLOCKED_DEPTH),
      .HANDLE_BITS   (HANDLE_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic rbtq_pkg::rsp_type apply_queue_op(input rbtq_pkg::req_type op);
      rbtq_pkg::rsp_type             res;
      logic [rbtq_pkg::HANDLE_W-1:0] h;
      int                            hit;
      res = '0;
      h = op.task_handle;
      hit = -1;
      case (op.kind)
         rbtq_pkg::KIND_PUSH: begin
            if (h != '0 && ready_cnt < READY_DEPTH) begin
               ready_mem[ready_cnt] = h;
               ready_cnt++;
               push_total++;
               res.ok = 1'b1;
            end else if (h != '0) begin
               full_push_refusals++;
            end
         end
         rbtq_pkg::KIND_POP: begin
            if (ready_cnt > 0) begin
               ready_cnt--;
               res.popped_handle = ready_mem[ready_cnt];
               res.ok = 1'b1;
            end
         end
         rbtq_pkg::KIND_APPEND: begin
            if (h != '0 && blocked_list.size() < BLOCKED_DEPTH) begin
               blocked_list.push_back(h);
               res.ok = 1'b1;
            end else if (h != '0) begin
               full_append_refusals++;
            end
         end
         default: begin
            if (h != '0) begin
               for (int i = 0; i < blocked_list.size(); i++)
                  if (hit < 0 && blocked_list[i] == h) hit = i;
               if (hit >= 0 && ready_cnt < READY_DEPTH) begin
                  ready_mem[ready_cnt] = h;
                  ready_cnt++;
                  blocked_list.delete(hit);
                  res.ok = 1'b1;
               end else if (hit >= 0) begin
                  held_unblocks++;
               end
            end
         end
      endcase
      if (ready_cnt > ready_peak) ready_peak = ready_cnt;
      if (blocked_list.size() > blocked_peak) blocked_peak = blocked_list.size();
      res.ready_level = rbtq_pkg::RLEVEL_W'(ready_cnt);
      res.blocked_level = rbtq_pkg::BLEVEL_W'(blocked_list.size());
      res.pushed_total = push_total;
      return res;
   endfunction

   function automatic logic [rbtq_pkg::HANDLE_W-1:0] pick_handle();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 5) return '0;
      if (roll < 10) return '1;
      if (roll < 40) return rbtq_pkg::HANDLE_W'($urandom);
      return rbtq_pkg::HANDLE_W'($urandom_range(12, 1));
   endfunction

   // unblock mostly targets a handle that is really blocked
   function automatic rbtq_pkg::req_type make_random_req(input op_mix_type mix);
      rbtq_pkg::req_type op;
      int unsigned       roll;
      int unsigned       w_push;
      int unsigned       w_pop;
      int unsigned       w_append;
      case (mix)
         MIX_FILL: begin
            w_push = 45; w_pop = 5; w_append = 40;
         end
         MIX_DRAIN: begin
            w_push = 5; w_pop = 55; w_append = 10;
         end
         default: begin
            w_push = 25; w_pop = 25; w_append = 25;
         end
      endcase
      roll = $urandom_range(99);
      if (roll < w_push) op.kind = rbtq_pkg::KIND_PUSH;
      else if (roll < w_push + w_pop) op.kind = rbtq_pkg::KIND_POP;
      else if (roll < w_push + w_pop + w_append) op.kind = rbtq_pkg::KIND_APPEND;
      else op.kind = rbtq_pkg::KIND_UNBLOCK;
      if (op.kind == rbtq_pkg::KIND_UNBLOCK && blocked_list.size() > 0 &&
          $urandom_range(99) < 70)
         op.task_handle = blocked_list[$urandom_range(blocked_list.size() - 1)];
      else
         op.task_handle = pick_handle();
      return op;
   endfunction

   task automatic send_req(input rbtq_pkg::req_type op, input logic typed,
                           input rbtq_pkg::rsp_type want);
      rbtq_pkg::rsp_type predicted;
      @(negedge clock);
      while ((idle_mode == IDLE_SENDER && $urandom_range(99) < 83) ||
             (idle_mode == IDLE_BOTH && $urandom_range(99) < 18)) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_item = op;
      do @(posedge clock); while (!req_ready);
      predicted = apply_queue_op(op);
      awaited_rsp.push_back(typed ? want : predicted);
      items_sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
   endtask

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready = 1'b0;
      end else begin
         case (idle_mode)
            IDLE_RECEIVER: rsp_ready = ($urandom_range(99) >= 83);
            IDLE_BOTH:     rsp_ready = ($urandom_range(99) >= 18);
            default:       rsp_ready = 1'b1;
         endcase
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles,
                  awaited_rsp.size());
         $display("ready_blocked_task_queues test failed");
         $finish;
      end else if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unrequested result item: %p", rsp_item);
         end else begin
            head_rsp = awaited_rsp.pop_front();
            results_checked++;
            if (rsp_item.ok !== head_rsp.ok ||
                rsp_item.popped_handle !== head_rsp.popped_handle ||
                rsp_item.ready_level !== head_rsp.ready_level ||
                rsp_item.blocked_level !== head_rsp.blocked_level ||
                rsp_item.pushed_total !== head_rsp.pushed_total) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $write("result %0d mismatch (exp/got): ok %0b/%0b popped %h/%h ",
                         results_checked,
                         head_rsp.ok, rsp_item.ok,
                         head_rsp.popped_handle, rsp_item.popped_handle);
                  $display("ready %0d/%0d blocked %0d/%0d total %0d/%0d",
                           head_rsp.ready_level, rsp_item.ready_level,
                           head_rsp.blocked_level, rsp_item.blocked_level,
                           head_rsp.pushed_total, rsp_item.pushed_total);
               end
            end
         end
      end
   end

   initial begin
      op_mix_type        mix;
      int unsigned       n;
      rbtq_pkg::req_type row_op;
      repeat (3) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      foreach (OPENING_OPS[i]) begin
         row_op.kind = OPENING_OPS[i].kind;
         row_op.task_handle = OPENING_OPS[i].task_handle;
         send_req(row_op, OPENING_OPS[i].typed, OPENING_OPS[i].want);
      end

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % PHASE_ITEMS == 0) begin
            wait_drained();
            idle_mode = idle_mode_type'(n / PHASE_ITEMS);
         end else if ($urandom_range(199) == 0) begin
            wait_drained();
         end
         if (n < 150) mix = MIX_EVEN;
         else if (n < 750) mix = MIX_FILL;
         else if (n < 1000) mix = MIX_DRAIN;
         else mix = MIX_EVEN;
         send_req(make_random_req(mix), 1'b0, '0);
      end

      @(negedge clock) req_valid = 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("%0d items (%0d table rows), %0d results checked, %0d mismatches",
               items_sent, OPENING_ROWS, results_checked, mismatches);
      $write("peak ready %0d/%0d, peak blocked %0d/%0d; refused: %0d pushes, ",
             ready_peak, READY_DEPTH, blocked_peak, BLOCKED_DEPTH, full_push_refusals);
      $display("%0d appends on full, %0d unblocks held by full ready",
               full_append_refusals, held_unblocks);
      if (mismatches == 0 && awaited_rsp.size() == 0) begin
         $display("ready_blocked_task_queues test passed");
      end else begin
         $display("ready_blocked_task_queues test failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/rbtq_pkg.sv
rtl/core/rbtq_ctrl.sv
rtl/core/rbtq_datapath.sv
rtl/core/ready_blocked_task_queues.sv
rtl/core/rbtq_checker.sv
verif/testbench.sv
